>>> design/mdra_pkg.sv
// ---------------------------------------------------------------------------
// mdra_pkg
// Shared types and constants of the motion delta report accumulator.
// ---------------------------------------------------------------------------
package mdra_pkg;

   localparam int SUM_WIDTH   = 32;
   localparam int DELTA_WIDTH = 16;
   localparam int TIME_WIDTH  = 32;
   localparam int CSR_WIDTH   = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int EVQ_DEPTH   = 4;
   localparam int EVQ_PTR_W   = $clog2(EVQ_DEPTH);
   localparam int EVQ_CNT_W   = $clog2(EVQ_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SWAP_AXES    = 3'd0,
      CSR_NEGATE_X     = 3'd1,
      CSR_NEGATE_Y     = 3'd2,
      CSR_INTERVAL     = 3'd3,
      CSR_EVENT_KIND   = 3'd4,
      CSR_X_EVENT_CODE = 3'd5,
      CSR_Y_EVENT_CODE = 3'd6
   } csr_index_type;

   localparam logic [CSR_WIDTH-1:0] EVENT_KIND_RESET   = 16'd2;
   localparam logic [CSR_WIDTH-1:0] X_EVENT_CODE_RESET = 16'd0;
   localparam logic [CSR_WIDTH-1:0] Y_EVENT_CODE_RESET = 16'd1;

   typedef struct packed {
      logic signed [DELTA_WIDTH-1:0] raw_dx;
      logic signed [DELTA_WIDTH-1:0] raw_dy;
      logic [TIME_WIDTH-1:0]         now_ms;
   } req_type;

   typedef struct packed {
      logic [15:0]                   kind;
      logic [15:0]                   code;
      logic signed [DELTA_WIDTH-1:0] amount;
      logic                          sync_last;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic purge;
      logic clear;
   } lane_ctl_type;

   typedef struct packed {
      logic signed [DELTA_WIDTH-1:0] amount;
      logic                          nonzero;
   } lane_res_type;

   typedef struct packed {
      logic purge;
      logic gated;
   } timer_stat_type;

endpackage

>>> design/motion_delta_report_accumulator.sv
// ---------------------------------------------------------------------------
// motion_delta_report_accumulator
// Swaps and negates motion samples, accumulates them per axis in two lanes
// and merges the lane results into X/Y report events.
// ---------------------------------------------------------------------------
//   port group | dir | handshake        | carries
//   req_       | in  | valid / ready    | raw_dx, raw_dy, now_ms
//   rsp_       | out | valid / ready    | kind, code, amount, sync_last
//   csr_       | in  | write enable     | register index, write data
//
// a request is registered on acceptance and updates the sums the next cycle,
// its events entering a four-entry queue; a report is one or two events
// requests are taken while the queue keeps room for two events beyond those
// owed: every cycle while reports and queue are empty, else as it drains
// synchronous reset clears sums, timestamps and queue, and resets registers
// a stalled result port fills the queue and then holds req_ready low
// ---------------------------------------------------------------------------
module motion_delta_report_accumulator
   import mdra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_WIDTH-1:0]  csr_wdata
);

   logic                 swap_ff, neg_x_ff, neg_y_ff;
   logic [CSR_WIDTH-1:0] interval_ff, kind_ff, x_code_ff, y_code_ff;

   logic                          s1_valid_ff, s1_valid_in;
   logic signed [DELTA_WIDTH-1:0] s1_dx_ff, s1_dy_ff;
   logic [TIME_WIDTH-1:0]         s1_now_ff;

   logic signed [DELTA_WIDTH-1:0] dx_sel, dy_sel, dx_adj, dy_adj;
   logic                          accept;
   logic [EVQ_CNT_W-1:0]          fill;
   logic [EVQ_CNT_W:0]            owed;

   timer_stat_type stat;
   lane_ctl_type   ctl;
   lane_res_type   res_x, res_y;
   logic           emit;
   logic [1:0]     push_count;
   rsp_type        ev_x, ev_y, push_first;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff     <= 1'b0;
         neg_x_ff    <= 1'b0;
         neg_y_ff    <= 1'b0;
         interval_ff <= '0;
         kind_ff     <= EVENT_KIND_RESET;
         x_code_ff   <= X_EVENT_CODE_RESET;
         y_code_ff   <= Y_EVENT_CODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SWAP_AXES:    swap_ff     <= csr_wdata[0];
            CSR_NEGATE_X:     neg_x_ff    <= csr_wdata[0];
            CSR_NEGATE_Y:     neg_y_ff    <= csr_wdata[0];
            CSR_INTERVAL:     interval_ff <= csr_wdata;
            CSR_EVENT_KIND:   kind_ff     <= csr_wdata;
            CSR_X_EVENT_CODE: x_code_ff   <= csr_wdata;
            CSR_Y_EVENT_CODE: y_code_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage: swap, then negate with wrap
   always_comb begin
      owed      = {1'b0, fill} + (s1_valid_ff ? (EVQ_CNT_W+1)'(2) : '0);
      req_ready = (owed <= (EVQ_CNT_W+1)'(EVQ_DEPTH - 2));
      accept    = req_valid && req_ready;
      dx_sel    = swap_ff ? req_data.raw_dy : req_data.raw_dx;
      dy_sel    = swap_ff ? req_data.raw_dx : req_data.raw_dy;
      dx_adj    = neg_x_ff ? -dx_sel : dx_sel;
      dy_adj    = neg_y_ff ? -dy_sel : dy_sel;
      s1_valid_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dx_ff  <= dx_adj;
         s1_dy_ff  <= dy_adj;
         s1_now_ff <= req_data.now_ms;
      end
   end

   mdra_timer u_timer (
      .clock    (clock),
      .reset    (reset),
      .valid    (s1_valid_ff),
      .emit     (emit),
      .now_ms   (s1_now_ff),
      .interval (interval_ff),
      .stat     (stat)
   );

   mdra_lane u_lane_x (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .delta (s1_dx_ff),
      .res   (res_x)
   );

   mdra_lane u_lane_y (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .delta (s1_dy_ff),
      .res   (res_y)
   );

   // merge: report decision and event build
   always_comb begin
      emit      = s1_valid_ff && !stat.gated && (res_x.nonzero || res_y.nonzero);
      ctl.valid = s1_valid_ff;
      ctl.purge = stat.purge;
      ctl.clear = emit;

      ev_x.kind      = kind_ff;
      ev_x.code      = x_code_ff;
      ev_x.amount    = res_x.amount;
      ev_x.sync_last = !res_y.nonzero;
      ev_y.kind      = kind_ff;
      ev_y.code      = y_code_ff;
      ev_y.amount    = res_y.amount;
      ev_y.sync_last = 1'b1;

      push_first = res_x.nonzero ? ev_x : ev_y;
      if (!emit) begin
         push_count = 2'd0;
      end else if (res_x.nonzero && res_y.nonzero) begin
         push_count = 2'd2;
      end else begin
         push_count = 2'd1;
      end
   end

   mdra_evq u_evq (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (ev_y),
      .fill        (fill),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

>>> design/mdra_lane.sv
// ---------------------------------------------------------------------------
// mdra_lane
// One axis: accumulator with purge, saturating add and 16-bit clamp.
// ---------------------------------------------------------------------------
module mdra_lane
   import mdra_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  lane_ctl_type                  ctl,
   input  logic signed [DELTA_WIDTH-1:0] delta,
   output lane_res_type                  res
);

   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
   localparam int UPPER_W = SUM_WIDTH - DELTA_WIDTH + 1;

   logic [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [SUM_WIDTH-1:0] base;
   logic [SUM_WIDTH:0]   wide;
   logic [SUM_WIDTH-1:0] sum_add;
   logic [UPPER_W-1:0]   upper;
   logic [DELTA_WIDTH-1:0] clamped;

   always_comb begin
      base = ctl.purge ? '0 : sum_ff;
      wide = {base[SUM_WIDTH-1], base}
           + {{(SUM_WIDTH-DELTA_WIDTH+1){delta[DELTA_WIDTH-1]}}, delta};
      if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]) begin
         sum_add = wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_add = wide[SUM_WIDTH-1:0];
      end
      // in 16-bit range when every bit from bit 15 up matches the sign
      upper = sum_add[SUM_WIDTH-1:DELTA_WIDTH-1];
      if (upper == '0 || upper == '1) begin
         clamped = sum_add[DELTA_WIDTH-1:0];
      end else if (sum_add[SUM_WIDTH-1]) begin
         clamped = {1'b1, {(DELTA_WIDTH-1){1'b0}}};
      end else begin
         clamped = {1'b0, {(DELTA_WIDTH-1){1'b1}}};
      end
      res.amount  = clamped;
      res.nonzero = (clamped != '0);
      sum_in = sum_ff;
      if (ctl.valid) begin
         sum_in = ctl.clear ? '0 : sum_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

>>> design/mdra_timer.sv
// ---------------------------------------------------------------------------
// mdra_timer
// Sample and report timestamps, purge and report gating decisions.
// ---------------------------------------------------------------------------
module mdra_timer
   import mdra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid,
   input  logic                  emit,
   input  logic [TIME_WIDTH-1:0] now_ms,
   input  logic [CSR_WIDTH-1:0]  interval,
   output timer_stat_type        stat
);

   logic [TIME_WIDTH-1:0] last_sample_ff, last_sample_in;
   logic [TIME_WIDTH-1:0] last_report_ff, last_report_in;
   logic [TIME_WIDTH-1:0] gap_sample, gap_report, ivl_wide;
   logic                  active;

   always_comb begin
      active     = (interval != '0);
      ivl_wide   = {{(TIME_WIDTH-CSR_WIDTH){1'b0}}, interval};
      gap_sample = now_ms - last_sample_ff;
      gap_report = now_ms - last_report_ff;
      stat.purge = active && (gap_sample >= ivl_wide);
      stat.gated = active && (gap_report < ivl_wide);
      last_sample_in = last_sample_ff;
      last_report_in = last_report_ff;
      if (valid && active) begin
         last_sample_in = now_ms;
      end
      if (emit && active) begin
         last_report_in = now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff <= '0;
         last_report_ff <= '0;
      end else begin
         last_sample_ff <= last_sample_in;
         last_report_ff <= last_report_in;
      end
   end

endmodule

>>> design/mdra_evq.sv
// ---------------------------------------------------------------------------
// mdra_evq
// Small event queue: takes up to two events a cycle, hands out one.
// ---------------------------------------------------------------------------
module mdra_evq
   import mdra_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  rsp_type              push_first,
   input  rsp_type              push_second,
   output logic [EVQ_CNT_W-1:0] fill,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   rsp_type                mem_ff [EVQ_DEPTH];
   logic [EVQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [EVQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [EVQ_CNT_W-1:0]   count_ff, count_in;
   logic [EVQ_PTR_W-1:0]   wr_next;
   logic                   pop;

   always_comb begin
      pop       = rsp_valid && rsp_ready;
      wr_next   = wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff + EVQ_PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + EVQ_CNT_W'(push_count) - EVQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign fill      = count_ff;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the motion delta report accumulator. A short table
// of hand-picked samples and register settings runs first, then a burst that
// holds the report back while both sums grow far past 16 bits, then phases of
// random samples under two fixed and then random settings. Every event is
// checked against the hand-typed table or an in-bench predictor.
// ---------------------------------------------------------------------------
module tb;
   import mdra_pkg::*;

   localparam int                   SETTLE_CYCLES   = 8;
   localparam int                   TAIL_CYCLES     = 16;
   localparam int                   STUCK_LIMIT     = 1000;
   localparam int                   HOLD_SAMPLES    = 40;
   localparam int                   RANDOM_PHASES   = 12;
   localparam int                   USE_MODEL       = -1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_WIDTH-1:0]  value;
      req_type               sample;
      int                    typed_n;
      rsp_type               ev0;
      rsp_type               ev1;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;

   // predictor copy of the registers and the running state
   bit                   cfg_swap     = 1'b0;
   bit                   cfg_negate_x = 1'b0;
   bit                   cfg_negate_y = 1'b0;
   bit [CSR_WIDTH-1:0]   cfg_interval = '0;
   bit [CSR_WIDTH-1:0]   cfg_kind     = EVENT_KIND_RESET;
   bit [CSR_WIDTH-1:0]   cfg_x_code   = X_EVENT_CODE_RESET;
   bit [CSR_WIDTH-1:0]   cfg_y_code   = Y_EVENT_CODE_RESET;
   longint               acc_x        = 0;
   longint               acc_y        = 0;
   bit [TIME_WIDTH-1:0]  sample_stamp = '0;
   bit [TIME_WIDTH-1:0]  report_stamp = '0;

   rsp_type              pending_events[$];
   plan_row_type         plan[$];
   rsp_type              want;
   bit                   csr_open     = 1'b0;
   bit                   calm         = 1'b0;
   bit [TIME_WIDTH-1:0]  stamp_ms     = '0;
   int                   samples_sent = 0;
   int                   events_checked = 0;
   int                   writes_done  = 0;
   int                   mismatches   = 0;
   int                   stuck_cycles = 0;

   motion_delta_report_accumulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic req_type make_sample(input logic [15:0] dx, input logic [15:0] dy,
                                           input logic [TIME_WIDTH-1:0] now);
      req_type s;
      s.raw_dx = dx;
      s.raw_dy = dy;
      s.now_ms = now;
      return s;
   endfunction

   function automatic rsp_type make_event(input logic [15:0] kind, input logic [15:0] code,
                                          input logic [15:0] amount, input logic last);
      rsp_type e;
      e.kind      = kind;
      e.code      = code;
      e.amount    = amount;
      e.sync_last = last;
      return e;
   endfunction

   function automatic longint saturate(input longint v);
      longint top;
      top = (longint'(1) << (SUM_WIDTH - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
   endfunction

   function automatic logic signed [DELTA_WIDTH-1:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   function automatic void model_config(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [CSR_WIDTH-1:0] value);
      case (idx)
         CSR_SWAP_AXES:    cfg_swap     = value[0];
         CSR_NEGATE_X:     cfg_negate_x = value[0];
         CSR_NEGATE_Y:     cfg_negate_y = value[0];
         CSR_INTERVAL:     cfg_interval = value;
         CSR_EVENT_KIND:   cfg_kind     = value;
         CSR_X_EVENT_CODE: cfg_x_code   = value;
         CSR_Y_EVENT_CODE: cfg_y_code   = value;
         default: ;
      endcase
   endfunction

   // advances the sums for one sample and returns the events of its report
   function automatic int predict_events(input req_type s, output rsp_type first,
                                         output rsp_type second);
      logic signed [DELTA_WIDTH-1:0] dx, dy, held, out_x, out_y;
      int                            n;
      dx     = s.raw_dx;
      dy     = s.raw_dy;
      first  = '0;
      second = '0;
      n      = 0;
      if (cfg_swap) begin
         held = dx;
         dx   = dy;
         dy   = held;
      end
      // minus 32768 wraps back onto itself
      if (cfg_negate_x) dx = -dx;
      if (cfg_negate_y) dy = -dy;
      if (cfg_interval != 0) begin
         if (32'(s.now_ms - sample_stamp) >= cfg_interval) begin
            acc_x = 0;
            acc_y = 0;
         end
         sample_stamp = s.now_ms;
      end
      acc_x = saturate(acc_x + dx);
      acc_y = saturate(acc_y + dy);
      if (cfg_interval != 0 && 32'(s.now_ms - report_stamp) < cfg_interval) return 0;
      out_x = clamp16(acc_x);
      out_y = clamp16(acc_y);
      // nothing to report: the sums are kept
      if (out_x == 0 && out_y == 0) return 0;
      if (cfg_interval != 0) report_stamp = s.now_ms;
      acc_x = 0;
      acc_y = 0;
      if (out_x != 0) begin
         first = make_event(cfg_kind, cfg_x_code, out_x, out_y == 0);
         n     = 1;
      end
      if (out_y != 0) begin
         if (n == 0) first = make_event(cfg_kind, cfg_y_code, out_y, 1'b1);
         else second = make_event(cfg_kind, cfg_y_code, out_y, 1'b1);
         n++;
      end
      return n;
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_WIDTH-1:0] value);
      plan_row_type row;
      row.kind    = ROW_WRITE;
      row.idx     = idx;
      row.value   = value;
      row.sample  = '0;
      row.typed_n = USE_MODEL;
      row.ev0     = '0;
      row.ev1     = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_known(input logic [15:0] dx, input logic [15:0] dy,
                                     input logic [TIME_WIDTH-1:0] now, input int n,
                                     input rsp_type ev0, input rsp_type ev1);
      plan_row_type row;
      row.kind    = ROW_SAMPLE;
      row.idx     = '0;
      row.value   = '0;
      row.sample  = make_sample(dx, dy, now);
      row.typed_n = n;
      row.ev0     = ev0;
      row.ev1     = ev1;
      plan.push_back(row);
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] random_delta();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 16'($urandom_range(0, 128) - 64);
      if (r < 65) return '0;
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return 16'h0001;
         endcase
      end
      return 16'($urandom());
   endfunction

   // mostly steps below the interval so sums build up, some purges, a few jumps
   function automatic logic [TIME_WIDTH-1:0] next_stamp();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (cfg_interval == 0 || r >= 96) stamp_ms = $urandom();
      else if (r < 50) stamp_ms += $urandom_range(0, cfg_interval - 1);
      else if (r < 75) stamp_ms += cfg_interval + $urandom_range(0, cfg_interval);
      else if (r >= 90) stamp_ms += 1;
      return stamp_ms;
   endfunction

   // waits for every owed event, then lets the block run dry before going on
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_events.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_WIDTH-1:0] value);
      if (!csr_open) settle(SETTLE_CYCLES);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_open = 1'b1;
      model_config(idx, value);
      writes_done++;
   endtask

   task automatic send_sample(input req_type s, input int typed_n, input rsp_type k0,
                              input rsp_type k1);
      int      gap;
      int      n;
      rsp_type e0, e1;
      if (csr_open) begin
         csr_we   <= 1'b0;
         csr_open = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      n = predict_events(s, e0, e1);
      if (typed_n != USE_MODEL) begin
         n  = typed_n;
         e0 = k0;
         e1 = k1;
      end
      if (n > 0) pending_events.push_back(e0);
      if (n > 1) pending_events.push_back(e1);
      samples_sent++;
   endtask

   task automatic program_phase(input int phase);
      logic                 sw, nx, ny;
      logic [CSR_WIDTH-1:0] ivl, kd, xc, yc;
      case (phase)
         0: begin
            sw = 1'b1; nx = 1'b1; ny = 1'b1;
            ivl = 16'hFFFF; kd = 16'hFFFF; xc = 16'hFFFF; yc = 16'hFFFF;
         end
         1: begin
            sw = 1'b0; nx = 1'b0; ny = 1'b0;
            ivl = 16'd1; kd = '0; xc = '0; yc = '0;
         end
         default: begin
            sw = 1'($urandom_range(0, 1));
            nx = 1'($urandom_range(0, 1));
            ny = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0:       ivl = '0;
               1:       ivl = 16'($urandom_range(1, 8));
               2:       ivl = 16'($urandom_range(9, 300));
               default: ivl = 16'($urandom());
            endcase
            kd = 16'($urandom());
            xc = 16'($urandom());
            yc = 16'($urandom());
         end
      endcase
      if ($urandom_range(0, 2) == 0) csr_write(CSR_SPARE_INDEX, 16'($urandom()));
      csr_write(CSR_SWAP_AXES, 16'(sw));
      csr_write(CSR_NEGATE_X, 16'(nx));
      csr_write(CSR_NEGATE_Y, 16'(ny));
      csr_write(CSR_INTERVAL, ivl);
      csr_write(CSR_EVENT_KIND, kd);
      csr_write(CSR_X_EVENT_CODE, xc);
      csr_write(CSR_Y_EVENT_CODE, yc);
   endtask

   // result side: random stalls, with calm stretches
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: event not expected: expected none, got kind %h code %h amount %0d last %b",
                     $time, rsp_data.kind, rsp_data.code, rsp_data.amount, rsp_data.sync_last);
            mismatches++;
         end else begin
            want = pending_events.pop_front();
            events_checked++;
            if (rsp_data.kind !== want.kind) begin
               $display("%0t: kind expected %h, got %h", $time, want.kind, rsp_data.kind);
               mismatches++;
            end
            if (rsp_data.code !== want.code) begin
               $display("%0t: code expected %h, got %h", $time, want.code, rsp_data.code);
               mismatches++;
            end
            if (rsp_data.amount !== want.amount) begin
               $display("%0t: amount expected %0d, got %0d", $time, want.amount, rsp_data.amount);
               mismatches++;
            end
            if (rsp_data.sync_last !== want.sync_last) begin
               $display("%0t: sync_last expected %b, got %b", $time, want.sync_last,
                        rsp_data.sync_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: nothing accepted for %0d cycles, %0d events still owed", $time,
                  STUCK_LIMIT, pending_events.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int                  count;
      logic [TIME_WIDTH-1:0] base;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, extremes of both deltas
      add_known(0, 0, 0, 0, '0, '0);
      add_known(1, 0, 1, 1, make_event(2, 0, 1, 1), '0);
      add_known(0, -1, 2, 1, make_event(2, 1, -1, 1), '0);
      add_known(32767, -32768, 3, 2, make_event(2, 0, 32767, 0), make_event(2, 1, -32768, 1));
      add_known(-32768, 32767, 4, 2, make_event(2, 0, -32768, 0), make_event(2, 1, 32767, 1));
      // negation, including the wrap of minus 32768
      add_write(CSR_NEGATE_X, 1);
      add_write(CSR_NEGATE_Y, 1);
      add_known(-32768, 5, 5, 2, make_event(2, 0, -32768, 0), make_event(2, 1, -5, 1));
      add_known(7, -32768, 6, 2, make_event(2, 0, -7, 0), make_event(2, 1, -32768, 1));
      // swapped axes, kind and X code at their top
      add_write(CSR_NEGATE_X, 0);
      add_write(CSR_NEGATE_Y, 0);
      add_write(CSR_SWAP_AXES, 1);
      add_write(CSR_EVENT_KIND, 16'hFFFF);
      add_write(CSR_X_EVENT_CODE, 16'hFFFF);
      add_write(CSR_Y_EVENT_CODE, 0);
      add_known(3, 0, 7, 1, make_event(16'hFFFF, 0, 3, 1), '0);
      add_known(0, -4, 8, 1, make_event(16'hFFFF, 16'hFFFF, -4, 1), '0);
      add_write(CSR_NEGATE_X, 1);
      add_write(CSR_NEGATE_Y, 1);
      add_known(-32768, 2, 9, 2, make_event(16'hFFFF, 16'hFFFF, -2, 0),
                make_event(16'hFFFF, 0, -32768, 1));
      // unused index must leave every register alone
      add_write(CSR_SPARE_INDEX, 16'hFFFF);
      add_write(CSR_SWAP_AXES, 0);
      add_write(CSR_NEGATE_X, 0);
      add_write(CSR_NEGATE_Y, 0);
      add_write(CSR_EVENT_KIND, 2);
      add_write(CSR_X_EVENT_CODE, 16'h5A5A);
      add_write(CSR_Y_EVENT_CODE, 16'hA5A5);
      // gating, purge of stale sums and time wrap
      add_write(CSR_INTERVAL, 10);
      add_known(4, 4, 100, 2, make_event(2, 16'h5A5A, 4, 0), make_event(2, 16'hA5A5, 4, 1));
      add_known(5, 0, 103, 0, '0, '0);
      add_known(0, 6, 105, 0, '0, '0);
      add_known(1, 1, 110, 2, make_event(2, 16'h5A5A, 6, 0), make_event(2, 16'hA5A5, 7, 1));
      add_known(9, 0, 115, 0, '0, '0);
      add_known(0, 0, 130, 0, '0, '0);
      add_known(0, 3, 32'hFFFF_FFFA, 1, make_event(2, 16'hA5A5, 3, 1), '0);
      add_known(2, 0, 2, 0, '0, '0);
      add_known(0, 0, 4, 1, make_event(2, 16'h5A5A, 2, 1), '0);
      // widest interval, and sums past 16 bits clamped on report
      add_write(CSR_INTERVAL, 16'hFFFF);
      add_known(-3, 0, 5, 0, '0, '0);
      add_known(0, 0, 65539, USE_MODEL, '0, '0);
      add_known(32767, -32768, 65540, 0, '0, '0);
      add_known(32767, -32768, 65541, 0, '0, '0);
      add_known(0, 0, 131074, 2, make_event(2, 16'h5A5A, 32767, 0),
                make_event(2, 16'hA5A5, -32768, 1));
      add_write(CSR_INTERVAL, 0);
      add_known(-1, 1, 0, USE_MODEL, '0, '0);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) csr_write(plan[i].idx, plan[i].value);
         else send_sample(plan[i].sample, plan[i].typed_n, plan[i].ev0, plan[i].ev1);
      end

      // hold the report back at a fixed time while both sums grow far past 16 bits
      csr_write(CSR_INTERVAL, 1000);
      base = report_stamp + 1;
      calm = 1'b1;
      repeat (HOLD_SAMPLES) send_sample(make_sample(16'h7FFF, 16'h8000, base), USE_MODEL, '0, '0);
      send_sample(make_sample(0, 0, base + 999), USE_MODEL, '0, '0);
      calm = 1'b0;

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_phase(phase);
         calm  = ($urandom_range(0, 3) == 0);
         count = $urandom_range(40, 90);
         repeat (count) begin
            if ($urandom_range(0, 59) == 0) settle(0);
            send_sample(make_sample(random_delta(), random_delta(), next_stamp()),
                        USE_MODEL, '0, '0);
         end
         calm = 1'b0;
      end

      settle(TAIL_CYCLES);
      $display("%0d samples over %0d register writes, %0d events checked", samples_sent,
               writes_done, events_checked);
      $display("swap, negation, gating, purge, time wrap and clamping of wide sums exercised");
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
design/mdra_pkg.sv
design/mdra_lane.sv
design/mdra_timer.sv
design/mdra_evq.sv
design/motion_delta_report_accumulator.sv
tb/tb.sv
